>>> rtl/core/ebb_pkg.sv
`default_nettype none

package ebb_pkg;

	// Port and field widths
	localparam int unsigned PCLK_W     = 30;
	localparam int unsigned TIM_W      = 16;
	localparam int unsigned RATE_W     = 18;
	localparam int unsigned NAME_HEAD_W = 64;
	localparam int unsigned NAME_TAIL_W = 40;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned WNUM_W     = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	localparam int unsigned BLOCK_WORDS = 32;
	localparam int unsigned NAME_LEN    = 13;

	// Pixel clock is carried in units of 10 kHz
	localparam int unsigned CLK_DIV          = 10000;
	localparam int unsigned PCLK_RECIP_SHIFT = 40;
	localparam logic [63:0] PCLK_RECIP_FULL  = (64'd1 << PCLK_RECIP_SHIFT) / CLK_DIV;
	localparam logic [26:0] PCLK_RECIP       = PCLK_RECIP_FULL[26:0];

	// Line rates are carried in kHz
	localparam int unsigned RATE_DIV          = 1000;
	localparam int unsigned RATE_RECIP_SHIFT  = 22;
	localparam logic [31:0] RATE_RECIP_FULL   = (32'd1 << RATE_RECIP_SHIFT) / RATE_DIV;
	localparam logic [12:0] RATE_RECIP        = RATE_RECIP_FULL[12:0];

	// Image size in millimeters
	localparam logic [11:0] SCREEN_W_MM = 12'd485;
	localparam logic [11:0] SCREEN_H_MM = 12'd364;

	localparam logic [7:0] DTD_FLAGS_BASE = 8'h18;
	localparam logic [7:0] TAG_RANGE      = 8'hfd;
	localparam logic [7:0] TAG_NAME       = 8'hfc;
	localparam logic [7:0] TAG_TEXT       = 8'hff;
	localparam logic [7:0] CHR_NL         = 8'h0a;
	localparam logic [7:0] CHR_SP         = 8'h20;

	// Header, vendor/product, version, basic display parameters,
	// chromaticity, no established and no standard timings
	localparam logic [0:53][7:0] HEAD_BYTES = {
		8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00,
		8'h48, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h24,
		8'h01, 8'h03, 8'h6d, 8'h30, 8'h24, 8'h78, 8'h0a,
		8'h5e, 8'hc0, 8'ha4, 8'h59, 8'h4a, 8'h98, 8'h25, 8'h20, 8'h50, 8'h54,
		8'h00, 8'h00, 8'h00,
		8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01,
		8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01
	};

	localparam logic [0:9][7:0] SERIAL_TEXT = {
		8'h52, 8'h65, 8'h74, 8'h72, 8'h6f, 8'h41, 8'h72, 8'h63, 8'h68, 8'h0a
	};

	// Queue between front and back
	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned FIFO_AW    = 1;
	localparam int unsigned FIFO_CW    = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VMIN      = 3'd0,
		CFG_VMAX      = 3'd1,
		CFG_HMIN      = 3'd2,
		CFG_HMAX      = 3'd3,
		CFG_NAME_HEAD = 3'd4,
		CFG_NAME_TAIL = 3'd5
	} cfg_reg_e;

	// One classified timing, already cut to its descriptor bit fields
	typedef struct packed {
		logic        rejected;
		logic [15:0] p10k;
		logic [11:0] ha;
		logic [11:0] hbl;
		logic [11:0] va;
		logic [11:0] vbl;
		logic [9:0]  hoff;
		logic [9:0]  hpw;
		logic [9:0]  voff;
		logic [9:0]  vpw;
		logic        interlaced;
		logic        hsync_positive;
		logic        vsync_positive;
	} entry_t;

	// Register contents as the back end consumes them
	typedef struct packed {
		logic [7:0]                vmin;
		logic [7:0]                vmax;
		logic [7:0]                hmin_khz;
		logic [7:0]                hmax_khz;
		logic [NAME_LEN-1:0][7:0]  name;
	} cfg_view_t;

endpackage

`default_nettype wire

>>> rtl/core/ebb_cfg.sv
`default_nettype none

module ebb_cfg import ebb_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_view_t                  view
);

	logic [7:0]             vmin_q;
	logic [7:0]             vmax_q;
	logic [RATE_W-1:0]      hmin_q;
	logic [RATE_W-1:0]      hmax_q;
	logic [NAME_HEAD_W-1:0] name_head_q;
	logic [NAME_TAIL_W-1:0] name_tail_q;

	logic [8:0] hmin_est_q;
	logic [8:0] hmax_est_q;
	logic [7:0] hmin_khz_q;
	logic [7:0] hmax_khz_q;

	logic [NAME_LEN-1:0][7:0] name_c;
	logic [NAME_LEN-1:0][7:0] name_q;

	// Low estimate of x / 1000, at most one short
	function automatic logic [8:0] rate_est(input logic [RATE_W-1:0] x);
		logic [30:0] prod;
		prod = 31'(x) * 31'(RATE_RECIP);
		return prod[30:22];
	endfunction

	// Correct the estimate and keep the low eight bits
	function automatic logic [7:0] rate_fix(input logic [RATE_W-1:0] x, input logic [8:0] est);
		logic [RATE_W-1:0] back;
		logic [RATE_W-1:0] rem;
		logic [8:0]        q;
		back = 18'(est) * 18'(RATE_DIV);
		rem  = x - back;
		q    = est + 9'(rem >= 18'(RATE_DIV));
		return q[7:0];
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmin_q      <= '0;
			vmax_q      <= '0;
			hmin_q      <= '0;
			hmax_q      <= '0;
			name_head_q <= '0;
			name_tail_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				CFG_VMIN:      vmin_q      <= cfg_data[7:0];
				CFG_VMAX:      vmax_q      <= cfg_data[7:0];
				CFG_HMIN:      hmin_q      <= cfg_data[RATE_W-1:0];
				CFG_HMAX:      hmax_q      <= cfg_data[RATE_W-1:0];
				CFG_NAME_HEAD: name_head_q <= cfg_data[NAME_HEAD_W-1:0];
				CFG_NAME_TAIL: name_tail_q <= cfg_data[NAME_TAIL_W-1:0];
				default: ;
			endcase
		end
	end

	// Name: characters up to the first zero, then newline, then spaces
	always_comb begin
		logic [8*NAME_LEN-1:0] raw;
		logic                  alive;
		logic [7:0]            ch;
		raw   = {name_tail_q, name_head_q};
		alive = 1'b1;
		for (int n = 0; n < NAME_LEN; n++) begin
			ch = raw[8*n +: 8];
			if (alive && ch != 8'h00) begin
				name_c[n] = ch;
			end else if (alive) begin
				name_c[n] = CHR_NL;
				alive     = 1'b0;
			end else begin
				name_c[n] = CHR_SP;
			end
		end
	end

	// Line rates are registered as an estimate, then corrected; the name is registered once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmin_est_q <= '0;
			hmax_est_q <= '0;
			hmin_khz_q <= '0;
			hmax_khz_q <= '0;
			name_q     <= '0;
		end else begin
			hmin_est_q <= rate_est(hmin_q);
			hmax_est_q <= rate_est(hmax_q);
			hmin_khz_q <= rate_fix(hmin_q, hmin_est_q);
			hmax_khz_q <= rate_fix(hmax_q, hmax_est_q);
			name_q     <= name_c;
		end
	end

	always_comb begin
		view.vmin     = vmin_q;
		view.vmax     = vmax_q;
		view.hmin_khz = hmin_khz_q;
		view.hmax_khz = hmax_khz_q;
		view.name     = name_q;
	end

endmodule

`default_nettype wire

>>> rtl/core/ebb_front.sv
`default_nettype none

module ebb_front import ebb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [PCLK_W-1:0] pixel_clock_hz,
	input  wire logic [TIM_W-1:0]  horiz_active,
	input  wire logic [TIM_W-1:0]  horiz_total,
	input  wire logic [TIM_W-1:0]  horiz_sync_start,
	input  wire logic [TIM_W-1:0]  horiz_sync_end,
	input  wire logic [TIM_W-1:0]  vert_active,
	input  wire logic [TIM_W-1:0]  vert_total,
	input  wire logic [TIM_W-1:0]  vert_sync_start,
	input  wire logic [TIM_W-1:0]  vert_sync_end,
	input  wire logic              interlaced,
	input  wire logic              hsync_positive,
	input  wire logic              vsync_positive,
	input  wire logic              full,
	output logic                   push,
	output entry_t                 entry
);

	logic adv;
	logic v_s1, v_s2, v_s3;

	// Stage 1: capture, reciprocal multiply
	logic [PCLK_W-1:0] pclk_s1;
	logic [TIM_W-1:0]  ha_s1, ht_s1, hs_s1, he_s1, va_s1, vt_s1, vs_s1, ve_s1;
	logic [2:0]        flags_s1;
	logic              rej_s1;
	logic [15:0]       est_s1;
	logic [56:0]       prod_c;

	// Stage 2: remainder, field differences
	logic [15:0] est_s2;
	logic [14:0] rem_s2;
	entry_t      ent_s2;
	entry_t      ent_c;
	logic [PCLK_W-1:0] back_c;
	logic [PCLK_W-1:0] rem_c;
	logic [TIM_W-1:0]  hbl_c, hoff_c, hpw_c, vbl_c, voff_c, vpw_c;

	entry_t ent_s3;
	entry_t ent_fix_c;

	// Whole front advances together; hold when the queue is full
	assign adv      = !v_s3 || !full;
	assign in_stall = !adv;
	assign push     = v_s3 && !full;
	assign entry    = ent_s3;

	assign prod_c = 57'(pixel_clock_hz) * 57'(PCLK_RECIP);

	always_comb begin
		back_c = 30'(est_s1) * 30'(CLK_DIV);
		rem_c  = pclk_s1 - back_c;
		hbl_c  = ht_s1 - ha_s1;
		hoff_c = hs_s1 - ha_s1;
		hpw_c  = he_s1 - hs_s1;
		vbl_c  = vt_s1 - va_s1;
		voff_c = vs_s1 - va_s1;
		vpw_c  = ve_s1 - vs_s1;

		ent_c.rejected       = rej_s1;
		ent_c.p10k           = '0;
		ent_c.ha             = ha_s1[11:0];
		ent_c.hbl            = hbl_c[11:0];
		ent_c.va             = va_s1[11:0];
		ent_c.vbl            = vbl_c[11:0];
		ent_c.hoff           = hoff_c[9:0];
		ent_c.hpw            = hpw_c[9:0];
		ent_c.voff           = voff_c[9:0];
		ent_c.vpw            = vpw_c[9:0];
		ent_c.interlaced     = flags_s1[2];
		ent_c.hsync_positive = flags_s1[1];
		ent_c.vsync_positive = flags_s1[0];

		// Bump the estimate when it came out one short
		ent_fix_c      = ent_s2;
		ent_fix_c.p10k = est_s2 + 16'(rem_s2 >= 15'(CLK_DIV));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pclk_s1  <= pixel_clock_hz;
			ha_s1    <= horiz_active;
			ht_s1    <= horiz_total;
			hs_s1    <= horiz_sync_start;
			he_s1    <= horiz_sync_end;
			va_s1    <= vert_active;
			vt_s1    <= vert_total;
			vs_s1    <= vert_sync_start;
			ve_s1    <= vert_sync_end;
			flags_s1 <= {interlaced, hsync_positive, vsync_positive};
			rej_s1   <= (pixel_clock_hz == '0) || (horiz_total == '0);
			est_s1   <= prod_c[55:40];

			est_s2 <= est_s1;
			rem_s2 <= rem_c[14:0];
			ent_s2 <= ent_c;

			ent_s3 <= ent_fix_c;
		end
	end

`ifndef SYNTHESIS
	// The reciprocal estimate is never more than one short
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> rem_s2 < 15'(2 * CLK_DIV))
		else $error("pixel clock remainder out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ebb_fifo.sv
`default_nettype none

module ebb_fifo import ebb_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t wr_entry,
	output logic        full,
	input  wire logic   pop,
	output logic        empty,
	output entry_t      rd_entry
);

	entry_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   cnt_q;

	function automatic logic [FIFO_AW-1:0] ptr_next(input logic [FIFO_AW-1:0] p);
		return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = cnt_q == FIFO_CW'(FIFO_DEPTH);
	assign empty    = cnt_q == '0;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == FIFO_CW'(FIFO_DEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ebb_back.sv
`default_nettype none

module ebb_back import ebb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              empty,
	input  wire entry_t            head,
	output logic                   pop,
	input  wire cfg_view_t         cfg,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [WORD_W-1:0]      block_word,
	output logic [WNUM_W-1:0]      word_number,
	output logic                   last_word,
	output logic                   rejected
);

	logic [WNUM_W-1:0] word_q;
	logic [7:0]        sum_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] block_word_q;
	logic [WNUM_W-1:0] word_number_q;
	logic              last_word_q;
	logic              rejected_q;

	logic       adv;
	logic       is_last;
	logic [7:0] b0, b1, b2, b3, b3_f, part;

	// One byte of the block; the checksum byte reads as zero here
	function automatic logic [7:0] byte_at(input logic [6:0] addr, input entry_t e,
	                                       input cfg_view_t c);
		logic [7:0] b;
		b = 8'h00;
		unique case (addr) inside
			[7'd0:7'd53]:   b = HEAD_BYTES[addr[5:0]];
			7'd54:          b = e.p10k[7:0];
			7'd55:          b = e.p10k[15:8];
			7'd56:          b = e.ha[7:0];
			7'd57:          b = e.hbl[7:0];
			7'd58:          b = {e.ha[11:8], e.hbl[11:8]};
			7'd59:          b = e.va[7:0];
			7'd60:          b = e.vbl[7:0];
			7'd61:          b = {e.va[11:8], e.vbl[11:8]};
			7'd62:          b = e.hoff[7:0];
			7'd63:          b = e.hpw[7:0];
			7'd64:          b = {e.voff[3:0], e.vpw[3:0]};
			7'd65:          b = {e.hoff[9:8], e.hpw[9:8], e.voff[9:8], e.vpw[9:8]};
			7'd66:          b = SCREEN_W_MM[7:0];
			7'd67:          b = SCREEN_H_MM[7:0];
			7'd68:          b = {SCREEN_W_MM[11:8], SCREEN_H_MM[11:8]};
			7'd71:          b = DTD_FLAGS_BASE | {e.interlaced, 4'b0000,
			                                      e.vsync_positive, e.hsync_positive, 1'b0};
			7'd75:          b = TAG_TEXT;
			[7'd77:7'd86]:  b = SERIAL_TEXT[4'(addr - 7'd77)];
			[7'd87:7'd89],
			[7'd102:7'd107]: b = CHR_SP;
			7'd93:          b = TAG_RANGE;
			7'd95:          b = c.vmin;
			7'd96:          b = c.vmax;
			7'd97:          b = c.hmin_khz;
			7'd98:          b = c.hmax_khz;
			7'd99:          b = TAG_TEXT;
			7'd101:         b = CHR_NL;
			7'd111:         b = TAG_NAME;
			[7'd113:7'd125]: b = c.name[4'(addr - 7'd113)];
			default:        b = 8'h00;
		endcase
		return b;
	endfunction

	// Load the output register when a timing is queued and the register is free or being taken
	assign adv     = !empty && (!out_valid_q || !out_stall);
	assign is_last = word_q == WNUM_W'(BLOCK_WORDS - 1);
	assign pop     = adv && (head.rejected || is_last);

	always_comb begin
		b0   = byte_at({word_q, 2'd0}, head, cfg);
		b1   = byte_at({word_q, 2'd1}, head, cfg);
		b2   = byte_at({word_q, 2'd2}, head, cfg);
		b3   = byte_at({word_q, 2'd3}, head, cfg);
		part = sum_q + b0 + b1 + b2;
		b3_f = is_last ? (8'h00 - part) : b3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			word_q      <= '0;
			sum_q       <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv && !head.rejected) begin
				word_q <= word_q + 1'b1;
				sum_q  <= is_last ? 8'h00 : part + b3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (head.rejected) begin
				block_word_q  <= '0;
				word_number_q <= '0;
				last_word_q   <= 1'b1;
				rejected_q    <= 1'b1;
			end else begin
				block_word_q  <= {b3_f, b2, b1, b0};
				word_number_q <= word_q;
				last_word_q   <= is_last;
				rejected_q    <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign block_word  = block_word_q;
	assign word_number = word_number_q;
	assign last_word   = last_word_q;
	assign rejected    = rejected_q;

`ifndef SYNTHESIS
	a_rej_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rejected_q |-> last_word_q && word_number_q == '0)
		else $error("rejection beat malformed");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rejected_q |->
			last_word_q == (word_number_q == WNUM_W'(BLOCK_WORDS - 1)))
		else $error("last flag on wrong word");

	a_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		word_q != '0 |-> !empty)
		else $error("block in progress without a queued timing");
`endif

endmodule

`default_nettype wire

>>> rtl/core/edid_block_builder_core.sv
`default_nettype none

// EDID 1.3 base block builder. Each timing beat accepted on the input channel
// yields one 128-byte base block on the output channel as 32 beats of four
// bytes, lowest-addressed byte in bits 7:0, word_number counting 0..31 and
// last_word marking beat 31; the final byte makes the block sum to zero. A
// timing with a zero pixel clock or zero horizontal total yields a single
// beat instead: all-zero word, word_number 0, last_word and rejected set.
// Rate: the back end produces one word per cycle while the output is not
// stalled and a timing is queued; blocks follow each other with no gap. A
// three-stage front end (pixel clock divide by reciprocal multiply, field
// differences) feeds a two-entry queue, so the next timing is taken while the
// current block is still streaming. From idle, the first word follows the
// three front stages, the queue entry and the output register. Registers are
// written through the cfg port (always ready); the user must write them only
// while the block is idle, which the block does not enforce. The derived line
// rates are registered as an estimate, then corrected; the name field once.
module edid_block_builder_core import ebb_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PCLK_W-1:0]     pixel_clock_hz,
	input  wire logic [TIM_W-1:0]      horiz_active,
	input  wire logic [TIM_W-1:0]      horiz_total,
	input  wire logic [TIM_W-1:0]      horiz_sync_start,
	input  wire logic [TIM_W-1:0]      horiz_sync_end,
	input  wire logic [TIM_W-1:0]      vert_active,
	input  wire logic [TIM_W-1:0]      vert_total,
	input  wire logic [TIM_W-1:0]      vert_sync_start,
	input  wire logic [TIM_W-1:0]      vert_sync_end,
	input  wire logic                  interlaced,
	input  wire logic                  hsync_positive,
	input  wire logic                  vsync_positive,

	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [WORD_W-1:0]          block_word,
	output logic [WNUM_W-1:0]          word_number,
	output logic                       last_word,
	output logic                       rejected
);

	cfg_view_t cfg_view;
	entry_t    push_entry;
	entry_t    head_entry;
	logic      push;
	logic      pop;
	logic      full;
	logic      empty;

	// Register file plus derived kHz rates and padded name
	ebb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.view      (cfg_view)
	);

	// Classify the timing and cut it to descriptor fields
	ebb_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.pixel_clock_hz   (pixel_clock_hz),
		.horiz_active     (horiz_active),
		.horiz_total      (horiz_total),
		.horiz_sync_start (horiz_sync_start),
		.horiz_sync_end   (horiz_sync_end),
		.vert_active      (vert_active),
		.vert_total       (vert_total),
		.vert_sync_start  (vert_sync_start),
		.vert_sync_end    (vert_sync_end),
		.interlaced       (interlaced),
		.hsync_positive   (hsync_positive),
		.vsync_positive   (vsync_positive),
		.full             (full),
		.push             (push),
		.entry            (push_entry)
	);

	// Decouple classification from block streaming
	ebb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.rd_entry (head_entry)
	);

	// Stream the block one word per cycle unless stalled, checksum on the last word
	ebb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head        (head_entry),
		.pop         (pop),
		.cfg         (cfg_view),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.block_word  (block_word),
		.word_number (word_number),
		.last_word   (last_word),
		.rejected    (rejected)
	);

endmodule

`default_nettype wire

>>> tb/edid_block_builder_core_tb.sv
module edid_block_builder_core_tb;
	import ebb_pkg::*;

	// Register indexes outside the map; writes there must leave everything alone
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_WAIT  = 8;
	localparam int DRAIN_WAIT   = 40;

	// One video timing as offered on the input channel
	typedef struct packed {
		logic [PCLK_W-1:0] pclk;
		logic [TIM_W-1:0]  h_act;
		logic [TIM_W-1:0]  h_tot;
		logic [TIM_W-1:0]  h_ss;
		logic [TIM_W-1:0]  h_se;
		logic [TIM_W-1:0]  v_act;
		logic [TIM_W-1:0]  v_tot;
		logic [TIM_W-1:0]  v_ss;
		logic [TIM_W-1:0]  v_se;
		logic              ilace;
		logic              hpos;
		logic              vpos;
	} timing_t;

	// One output beat as it should appear
	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [WNUM_W-1:0] pos;
		logic              last;
		logic              rej;
	} edid_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [PCLK_W-1:0]     pixel_clock_hz = '0;
	logic [TIM_W-1:0]      horiz_active = '0;
	logic [TIM_W-1:0]      horiz_total = '0;
	logic [TIM_W-1:0]      horiz_sync_start = '0;
	logic [TIM_W-1:0]      horiz_sync_end = '0;
	logic [TIM_W-1:0]      vert_active = '0;
	logic [TIM_W-1:0]      vert_total = '0;
	logic [TIM_W-1:0]      vert_sync_start = '0;
	logic [TIM_W-1:0]      vert_sync_end = '0;
	logic                  interlaced = 1'b0;
	logic                  hsync_positive = 1'b0;
	logic                  vsync_positive = 1'b0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [WORD_W-1:0]     block_word;
	logic [WNUM_W-1:0]     word_number;
	logic                  last_word;
	logic                  rejected;

	// Mirror of the register file, updated at each config handshake
	logic [7:0]             rate_vmin = '0;
	logic [7:0]             rate_vmax = '0;
	logic [RATE_W-1:0]      line_hmin = '0;
	logic [RATE_W-1:0]      line_hmax = '0;
	logic [NAME_HEAD_W-1:0] name_head = '0;
	logic [NAME_TAIL_W-1:0] name_tail = '0;

	// Predictor state: next word position within a block, sum of the last block
	logic [WNUM_W-1:0] word_pos = '0;
	logic [7:0]        block_sum = '0;

	timing_t    pending_timings[$];
	edid_beat_t expected_beats[$];
	timing_t    offered;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	int errors = 0;
	int cycle_count = 0;
	int items_taken = 0;
	int rejects_taken = 0;
	int beats_checked = 0;
	int settings_used = 1;

	edid_block_builder_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.pixel_clock_hz   (pixel_clock_hz),
		.horiz_active     (horiz_active),
		.horiz_total      (horiz_total),
		.horiz_sync_start (horiz_sync_start),
		.horiz_sync_end   (horiz_sync_end),
		.vert_active      (vert_active),
		.vert_total       (vert_total),
		.vert_sync_start  (vert_sync_start),
		.vert_sync_end    (vert_sync_end),
		.interlaced       (interlaced),
		.hsync_positive   (hsync_positive),
		.vsync_positive   (vsync_positive),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.block_word       (block_word),
		.word_number      (word_number),
		.last_word        (last_word),
		.rejected         (rejected)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// Build the 128-byte block a timing should produce and queue its 32 beats.
	// A zero pixel clock or zero horizontal total yields one rejection beat
	// and leaves the predictor state alone.
	task automatic predict_block(input timing_t t);
		logic [7:0]        blk [0:127];
		logic [31:0]       p10k, hbl, hoff, hpw, vbl, voff, vpw;
		logic [RATE_W-1:0] khz_min, khz_max;
		logic [7:0]        sum, chr;
		edid_beat_t        b;
		int                i, n;
		if (t.pclk == '0 || t.h_tot == '0) begin
			b.data = '0;
			b.pos = '0;
			b.last = 1'b1;
			b.rej = 1'b1;
			expected_beats.push_back(b);
			rejects_taken++;
			return;
		end

		// Differences wrap; only the low bits of each reach the descriptor
		p10k = {2'b00, t.pclk} / CLK_DIV;
		hbl  = 32'(t.h_tot) - 32'(t.h_act);
		hoff = 32'(t.h_ss) - 32'(t.h_act);
		hpw  = 32'(t.h_se) - 32'(t.h_ss);
		vbl  = 32'(t.v_tot) - 32'(t.v_act);
		voff = 32'(t.v_ss) - 32'(t.v_act);
		vpw  = 32'(t.v_se) - 32'(t.v_ss);
		khz_min = RATE_W'(line_hmin / RATE_DIV);
		khz_max = RATE_W'(line_hmax / RATE_DIV);

		for (i = 0; i < 128; i++)
			blk[i] = 8'h00;
		for (i = 0; i < 54; i++)
			blk[i] = HEAD_BYTES[i];

		// Detailed timing descriptor
		blk[54] = p10k[7:0];
		blk[55] = p10k[15:8];
		blk[56] = t.h_act[7:0];
		blk[57] = hbl[7:0];
		blk[58] = {t.h_act[11:8], hbl[11:8]};
		blk[59] = t.v_act[7:0];
		blk[60] = vbl[7:0];
		blk[61] = {t.v_act[11:8], vbl[11:8]};
		blk[62] = hoff[7:0];
		blk[63] = hpw[7:0];
		blk[64] = {voff[3:0], vpw[3:0]};
		blk[65] = {hoff[9:8], hpw[9:8], voff[9:8], vpw[9:8]};
		blk[66] = SCREEN_W_MM[7:0];
		blk[67] = SCREEN_H_MM[7:0];
		blk[68] = {SCREEN_W_MM[11:8], SCREEN_H_MM[11:8]};
		blk[71] = DTD_FLAGS_BASE | {t.ilace, 4'b0000, t.vpos, t.hpos, 1'b0};

		// Serial text descriptor
		blk[75] = TAG_TEXT;
		for (i = 0; i < 10; i++)
			blk[77 + i] = SERIAL_TEXT[i];
		for (i = 87; i < 90; i++)
			blk[i] = CHR_SP;

		// Range limits descriptor
		blk[93]  = TAG_RANGE;
		blk[95]  = rate_vmin;
		blk[96]  = rate_vmax;
		blk[97]  = khz_min[7:0];
		blk[98]  = khz_max[7:0];
		blk[99]  = 8'hff;
		blk[101] = CHR_NL;
		for (i = 102; i < 108; i++)
			blk[i] = CHR_SP;

		// Name descriptor: stop at the first zero byte, then newline and pad
		blk[111] = TAG_NAME;
		n = 0;
		while (n < NAME_LEN) begin
			chr = (n < 8) ? name_head[8*n +: 8] : name_tail[8*(n-8) +: 8];
			if (chr == 8'h00)
				break;
			blk[113 + n] = chr;
			n++;
		end
		if (n < NAME_LEN) begin
			blk[113 + n] = CHR_NL;
			n++;
		end
		while (n < NAME_LEN) begin
			blk[113 + n] = CHR_SP;
			n++;
		end

		sum = 8'h00;
		for (i = 0; i < 127; i++)
			sum = sum + blk[i];
		blk[127] = 8'h00 - sum;
		block_sum = sum + blk[127];

		for (i = 0; i < BLOCK_WORDS; i++) begin
			b.data = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
			b.pos = word_pos;
			b.last = (i == BLOCK_WORDS - 1);
			b.rej = 1'b0;
			expected_beats.push_back(b);
			word_pos = word_pos + 1'b1;
		end
	endtask

	// Drive: present the next pending timing unless idling; hold it while stalled
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_block(offered);
			items_taken++;
		end
		if (!in_valid || !in_stall) begin
			if (arst_n && pending_timings.size() != 0
					&& $urandom_range(99) >= send_idle_pct) begin
				offered = pending_timings.pop_front();
				in_valid         <= 1'b1;
				pixel_clock_hz   <= offered.pclk;
				horiz_active     <= offered.h_act;
				horiz_total      <= offered.h_tot;
				horiz_sync_start <= offered.h_ss;
				horiz_sync_end   <= offered.h_se;
				vert_active      <= offered.v_act;
				vert_total       <= offered.v_tot;
				vert_sync_start  <= offered.v_ss;
				vert_sync_end    <= offered.v_se;
				interlaced       <= offered.ilace;
				hsync_positive   <= offered.hpos;
				vsync_positive   <= offered.vpos;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Count down the long receiver hold-off once the pressure phase arms it
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	function automatic void check_field(input string fname, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, got %0h", fname, exp_v, act_v);
			errors++;
		end
	endfunction

	// Check every accepted output beat against the oldest expectation
	always @(posedge clk) begin
		edid_beat_t b;
		if (out_valid && !out_stall) begin
			if (expected_beats.size() == 0) begin
				$error("beat with nothing expected: word %0h number %0d", block_word,
					word_number);
				errors++;
			end else begin
				b = expected_beats.pop_front();
				check_field("block_word", b.data, block_word);
				check_field("word_number", 32'(b.pos), 32'(word_number));
				check_field("last_word", 32'(b.last), 32'(last_word));
				check_field("rejected", 32'(b.rej), 32'(rejected));
				beats_checked++;
			end
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("edid_block_builder_core test failed");
			$finish;
		end
	end

	// Write one register and update the mirror at the handshake edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_VMIN:      rate_vmin = data[7:0];
			CFG_VMAX:      rate_vmax = data[7:0];
			CFG_HMIN:      line_hmin = data[RATE_W-1:0];
			CFG_HMAX:      line_hmax = data[RATE_W-1:0];
			CFG_NAME_HEAD: name_head = data;
			CFG_NAME_TAIL: name_tail = data[NAME_TAIL_W-1:0];
			default:       ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// Random rates with random upper garbage; a name of the given length
	// followed by a zero byte and then random bytes that must be ignored
	task automatic set_random_config(input int len);
		logic [NAME_LEN*8-1:0] chars;
		int                    n;
		for (n = 0; n < NAME_LEN; n++) begin
			if (n < len)
				chars[8*n +: 8] = 8'($urandom_range(1, 255));
			else if (n == len)
				chars[8*n +: 8] = 8'h00;
			else
				chars[8*n +: 8] = 8'($urandom_range(255));
		end
		write_reg(CFG_VMIN, {$urandom, $urandom});
		write_reg(CFG_VMAX, {$urandom, $urandom});
		write_reg(CFG_HMIN, {$urandom, $urandom});
		write_reg(CFG_HMAX, {$urandom, $urandom});
		write_reg(CFG_NAME_HEAD, chars[63:0]);
		write_reg(CFG_NAME_TAIL, {$urandom, chars[103:72]});
		// Write the whole tail again with every name byte in place, terminator included
		write_reg(CFG_NAME_TAIL, {24'($urandom), chars[103:64]});
		settings_used++;
	endtask

	function automatic timing_t mk_timing(input logic [PCLK_W-1:0] pclk,
			input logic [TIM_W-1:0] ha, input logic [TIM_W-1:0] ht,
			input logic [TIM_W-1:0] hs, input logic [TIM_W-1:0] he,
			input logic [TIM_W-1:0] va, input logic [TIM_W-1:0] vt,
			input logic [TIM_W-1:0] vs, input logic [TIM_W-1:0] ve,
			input logic [2:0] flags);
		timing_t t;
		t.pclk = pclk;
		t.h_act = ha;
		t.h_tot = ht;
		t.h_ss = hs;
		t.h_se = he;
		t.v_act = va;
		t.v_tot = vt;
		t.v_ss = vs;
		t.v_se = ve;
		{t.ilace, t.hpos, t.vpos} = flags;
		return t;
	endfunction

	// Mostly plausible modes, a good share of raw random bits, a few rejections
	function automatic timing_t random_timing();
		timing_t t;
		int      pick;
		pick = $urandom_range(99);
		t.pclk = PCLK_W'($urandom);
		t.h_act = TIM_W'($urandom);
		t.h_tot = TIM_W'($urandom);
		t.h_ss = TIM_W'($urandom);
		t.h_se = TIM_W'($urandom);
		t.v_act = TIM_W'($urandom);
		t.v_tot = TIM_W'($urandom);
		t.v_ss = TIM_W'($urandom);
		t.v_se = TIM_W'($urandom);
		{t.ilace, t.hpos, t.vpos} = 3'($urandom);
		if (pick < 3) begin
			t.pclk = '0;
		end else if (pick < 6) begin
			t.h_tot = '0;
		end else if (pick >= 40) begin
			t.pclk = PCLK_W'($urandom_range(655359999, 10000000));
			t.h_act = TIM_W'($urandom_range(4200, 16));
			t.h_ss = t.h_act + TIM_W'($urandom_range(200));
			t.h_se = t.h_ss + TIM_W'($urandom_range(300, 1));
			t.h_tot = t.h_se + TIM_W'($urandom_range(300));
			t.v_act = TIM_W'($urandom_range(4200, 16));
			t.v_ss = t.v_act + TIM_W'($urandom_range(60));
			t.v_se = t.v_ss + TIM_W'($urandom_range(20, 1));
			t.v_tot = t.v_se + TIM_W'($urandom_range(80));
		end
		return t;
	endfunction

	// Wait until every timing is taken and every beat has come, then settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_timings.size() != 0 || in_valid || expected_beats.size() != 0);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic run_random(input int count, input int idle_pct, input int stall_pct);
		int i;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (i = 0; i < count; i++)
			pending_timings.push_back(random_timing());
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed set under reset register values (empty name, zero rates)
		pending_timings.push_back(mk_timing(25175000, 640, 800, 656, 752,
			480, 525, 490, 492, 3'b000));
		pending_timings.push_back(mk_timing(148500000, 1920, 2200, 2008, 2052,
			1080, 1125, 1084, 1089, 3'b011));
		pending_timings.push_back(mk_timing(74250000, 1920, 2200, 2008, 2052,
			540, 562, 542, 547, 3'b111));
		pending_timings.push_back(mk_timing(0, 640, 800, 656, 752,
			480, 525, 490, 492, 3'b000));
		pending_timings.push_back(mk_timing(25175000, 640, 0, 656, 752,
			480, 525, 490, 492, 3'b000));
		pending_timings.push_back(mk_timing(0, 0, 0, 0, 0, 0, 0, 0, 0, 3'b000));
		pending_timings.push_back(mk_timing('1, '1, '1, '1, '1, '1, '1, '1, '1, 3'b111));
		pending_timings.push_back(mk_timing(1, 0, 1, 0, 0, 0, 0, 0, 0, 3'b000));
		// Every difference negative
		pending_timings.push_back(mk_timing(40000000, 4000, 100, 50, 10,
			3000, 20, 10, 5, 3'b010));
		// Pixel clock just below one unit, at the top of 16 bits, and one past it
		pending_timings.push_back(mk_timing(9999, 1, 1, 1, 1, 1, 1, 1, 1, 3'b000));
		pending_timings.push_back(mk_timing(655359999, 800, 1000, 820, 900,
			600, 700, 610, 620, 3'b000));
		pending_timings.push_back(mk_timing(655360000, 800, 1000, 820, 900,
			600, 700, 610, 620, 3'b000));
		pending_timings.push_back(mk_timing(50000000, 1024, 1344, 1048, 1184,
			768, 806, 771, 777, 3'b100));
		pending_timings.push_back(mk_timing(50000000, 1024, 1344, 1048, 1184,
			768, 806, 771, 777, 3'b010));
		pending_timings.push_back(mk_timing(50000000, 1024, 1344, 1048, 1184,
			768, 806, 771, 777, 3'b001));
		// Twelve-bit field edges and full ten-bit sync offsets and pulses
		pending_timings.push_back(mk_timing(300000000, 4095, 8190, 5118, 6141,
			4095, 8190, 5118, 6141, 3'b101));
		pending_timings.push_back(mk_timing(300000000, 4096, 16'h1fff, 16'h1fff, 16'h2fff,
			4096, 16'h1fff, 16'h1fff, 16'h2fff, 3'b110));
		pending_timings.push_back(mk_timing(30'h2aaaaaaa, 16'haaaa, 16'h5555, 16'haaaa,
			16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 3'b101));
		pending_timings.push_back(mk_timing(30'h15555555, 16'h5555, 16'haaaa, 16'h5555,
			16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 3'b010));
		pending_timings.push_back(mk_timing(1, 1, 0, 1, 1, 1, 1, 1, 1, 3'b111));
		pending_timings.push_back(mk_timing(108000000, 1280, 1688, 1328, 1440,
			1024, 1066, 1025, 1028, 3'b011));
		wait_drained();

		// Top of each register (HMAX at the top kHz byte instead), thirteen-character name with no newline
		write_reg(CFG_VMIN, 64'd255);
		write_reg(CFG_VMAX, 64'd255);
		write_reg(CFG_HMIN, 64'h3ffff);
		write_reg(CFG_HMAX, 64'd255999);
		write_reg(CFG_NAME_HEAD, 64'h4847_4645_4443_4241);
		write_reg(CFG_NAME_TAIL, 64'h0000_00ff_807f_4d4c);
		settings_used++;
		repeat (SETTLE_WAIT) @(negedge clk);
		run_random(60, 75, 0);

		// Zero values hidden under garbage high bits, empty name, spare indexes
		write_reg(CFG_VMIN, 64'hdead_beef_0000_0000);
		write_reg(CFG_VMAX, 64'hffff_ffff_ffff_ff00);
		write_reg(CFG_HMIN, 64'hffff_ffff_fffc_0000);
		write_reg(CFG_HMAX, 64'd999);
		write_reg(CFG_NAME_HEAD, 64'h5a5a_5a5a_5a5a_5a00);
		write_reg(CFG_NAME_TAIL, 64'hffff_ff12_3456_7800);
		write_reg(CFG_SPARE_LO, {$urandom, $urandom});
		write_reg(CFG_SPARE_HI, {$urandom, $urandom});
		settings_used++;
		repeat (SETTLE_WAIT) @(negedge clk);
		run_random(60, 0, 75);

		set_random_config($urandom_range(11, 1));
		repeat (SETTLE_WAIT) @(negedge clk);
		run_random(60, 21, 21);

		// Twelve characters; hold the output off so the input backs up
		set_random_config(12);
		repeat (SETTLE_WAIT) @(negedge clk);
		hold_armed = 1'b1;
		run_random(40, 0, 0);

		// Name ends exactly where head and tail meet
		set_random_config(8);
		repeat (SETTLE_WAIT) @(negedge clk);
		run_random(40, 0, 0);

		repeat (DRAIN_WAIT) @(negedge clk);
		if (expected_beats.size() != 0) begin
			$error("%0d beats never arrived", expected_beats.size());
			errors++;
		end

		$display("Covered %0d timings (%0d rejected) across %0d register settings,",
			items_taken, rejects_taken, settings_used);
		$display("checking %0d output beats under idle, stall and back-pressure phases.",
			beats_checked);
		if (errors == 0) begin
			$display("edid_block_builder_core test passed");
		end else begin
			$display("edid_block_builder_core test failed");
		end
		$finish;
	end

endmodule
